### hdl/cfms_pkg.sv
// ----------------------------------------------------------------------------
// cfms_pkg: shared definitions for the circular FIFO with modify and search
// Sizes, operation and status codes, control/status bundles and pointer
// arithmetic helpers used by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package cfms_pkg;

  // storage geometry
  localparam int DEPTH   = 32;
  localparam int DATA_W  = 32;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = PTR_W + 1;

  // port field widths
  localparam int OP_W    = 2;
  localparam int POS_W   = 5;
  localparam int FOUND_W = 5;
  localparam int STAT_W  = 3;
  localparam int OCC_W   = 6;

  // width for comparing an offset against the entry count
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_MOD  = 2'd2,
    OP_SRCH = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADOFF   = 3'd3,
    STS_NOTFOUND = 3'd4
  } sts_t;

  // commands from controller to datapath
  typedef struct packed {
    logic latch;      // capture a new request
    logic we;         // write the storage
    logic wr_tail;    // write address: tail (else head + position)
    logic push;       // tail and count advance
    logic pop;        // head advances, count drops
    logic rd_en;      // read the storage at head + scan offset
    logic k_inc;      // step the scan offset
    logic finish;     // register the result
    logic take_data;  // result data from storage read
    logic take_found; // result offset from scan offset
    sts_t status;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic bad_off;
    logic match;
    logic last;
  } stat_t;

  // (a + b) mod DEPTH for a, b below DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                input logic [PTR_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SUM_W'(DEPTH)) begin
      s = s - SUM_W'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // pointer increment with wrap
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

### hdl/cfms_ram.sv
// ----------------------------------------------------------------------------
// cfms_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cfms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hdl/cfms_ctrl.sv
// ----------------------------------------------------------------------------
// cfms_ctrl: request sequencer
// Decides each step of a request from datapath status and issues commands;
// drives busy and the result strobe.
// ----------------------------------------------------------------------------
module cfms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  cfms_pkg::stat_t stat,
  output cfms_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           out_valid
);

  import cfms_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DEQ,
    S_SRCH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt      = state_r;
    cmd.latch      = 1'b0;
    cmd.we         = 1'b0;
    cmd.wr_tail    = 1'b0;
    cmd.push       = 1'b0;
    cmd.pop        = 1'b0;
    cmd.rd_en      = 1'b0;
    cmd.k_inc      = 1'b0;
    cmd.finish     = 1'b0;
    cmd.take_data  = 1'b0;
    cmd.take_found = 1'b0;
    cmd.status     = STS_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat.op)
          OP_ENQ: begin
            cmd.finish = 1'b1;
            if (stat.full) begin
              cmd.status = STS_FULL;
            end else begin
              cmd.we      = 1'b1;
              cmd.wr_tail = 1'b1;
              cmd.push    = 1'b1;
            end
          end
          OP_DEQ: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.status = STS_EMPTY;
            end else begin
              cmd.rd_en = 1'b1;
            end
          end
          OP_MOD: begin
            cmd.finish = 1'b1;
            if (stat.bad_off) begin
              cmd.status = STS_BADOFF;
            end else begin
              cmd.we = 1'b1;
            end
          end
          OP_SRCH: begin
            if (stat.empty) begin
              cmd.finish = 1'b1;
              cmd.status = STS_NOTFOUND;
            end else begin
              cmd.rd_en = 1'b1;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
        if (cmd.finish) begin
          state_nxt = S_IDLE;
        end else if (stat.op == OP_DEQ) begin
          state_nxt = S_DEQ;
        end else begin
          state_nxt = S_SRCH;
        end
      end
      S_DEQ: begin
        // head word has arrived from storage
        cmd.pop       = 1'b1;
        cmd.take_data = 1'b1;
        cmd.finish    = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_SRCH: begin
        // one entry compared per cycle, next read issued alongside
        if (stat.match) begin
          cmd.take_found = 1'b1;
          cmd.finish     = 1'b1;
          state_nxt      = S_IDLE;
        end else if (stat.last) begin
          cmd.status = STS_NOTFOUND;
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.k_inc = 1'b1;
          cmd.rd_en = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

endmodule

### hdl/cfms_dp.sv
// ----------------------------------------------------------------------------
// cfms_dp: FIFO datapath
// Ring storage, head/tail pointers, entry count, scan offset, request
// capture and result registers.
// ----------------------------------------------------------------------------
module cfms_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfms_pkg::cmd_t                  cmd,
  output cfms_pkg::stat_t                 stat,
  input  logic [cfms_pkg::OP_W-1:0]       in_operation,
  input  logic signed [cfms_pkg::DATA_W-1:0] in_value,
  input  logic [cfms_pkg::POS_W-1:0]      in_position,
  output logic signed [cfms_pkg::DATA_W-1:0] out_data,
  output logic [cfms_pkg::FOUND_W-1:0]    out_found_offset,
  output logic [cfms_pkg::STAT_W-1:0]     out_status,
  output logic [cfms_pkg::OCC_W-1:0]      out_occupancy
);

  import cfms_pkg::*;

  // request capture
  op_t               op_r;
  logic [DATA_W-1:0] val_r;
  logic [POS_W-1:0]  pos_r;

  // queue state
  logic [PTR_W-1:0]  head_r, tail_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  k_r, k_nxt;

  // results
  logic [DATA_W-1:0]  data_r;
  logic [FOUND_W-1:0] found_r;
  sts_t               status_r;
  logic [OCC_W-1:0]   occ_r;

  // storage ports
  logic [PTR_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] rdata;

  // count and scan offset next values
  always_comb begin
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign k_nxt = cmd.k_inc ? (k_r + PTR_W'(1)) : k_r;

  // storage addressing
  assign waddr = cmd.wr_tail ? tail_r : wrap_add(head_r, PTR_W'(pos_r));
  assign raddr = wrap_add(head_r, k_nxt);

  cfms_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (waddr),
    .wdata (val_r),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status to the controller
  assign stat.op      = op_r;
  assign stat.full    = (count_r == CNT_W'(DEPTH));
  assign stat.empty   = (count_r == '0);
  assign stat.bad_off = (CMP_W'(pos_r) >= CMP_W'(count_r));
  assign stat.match   = (rdata == val_r);
  assign stat.last    = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);

  // request capture and scan offset
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= op_t'(in_operation);
      val_r <= in_value;
      pos_r <= in_position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else if (cmd.latch) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (cmd.push) begin
        tail_r <= ptr_inc(tail_r);
      end
      if (cmd.pop) begin
        head_r <= ptr_inc(head_r);
      end
      count_r <= count_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      data_r   <= cmd.take_data ? rdata : '0;
      found_r  <= cmd.take_found ? FOUND_W'(k_r) : '0;
      status_r <= cmd.status;
      occ_r    <= OCC_W'(count_nxt);
    end
  end

  assign out_data         = data_r;
  assign out_found_offset = found_r;
  assign out_status       = status_r;
  assign out_occupancy    = occ_r;

endmodule

### hdl/circular_fifo_with_modify_search.sv
// Enqueue, modify, and dequeue or search of an empty queue finish in the
// execute step; any other dequeue first reads the head word from storage;
// any other search compares entries from the head, up to 32, one storage read
// a cycle. A new request is taken in the cycle the previous result is strobed.
// Reset clears the pointers and the entry count; storage contents start
// undefined. The receiver cannot stall: each result is shown for one cycle.
// ----------------------------------------------------------------------------
// circular_fifo_with_modify_search: ring-buffer FIFO with modify and search
// Enqueue, dequeue, overwrite at an offset from the head, and linear search
// from the head; one result per request.
// ----------------------------------------------------------------------------
module circular_fifo_with_modify_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [cfms_pkg::OP_W-1:0]           in_operation,
  input  logic signed [cfms_pkg::DATA_W-1:0]  in_value,
  input  logic [cfms_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  output logic signed [cfms_pkg::DATA_W-1:0]  out_data,
  output logic [cfms_pkg::FOUND_W-1:0]        out_found_offset,
  output logic [cfms_pkg::STAT_W-1:0]         out_status,
  output logic [cfms_pkg::OCC_W-1:0]          out_occupancy
);

  import cfms_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer
  cfms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // storage and queue state
  cfms_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_data         (out_data),
    .out_found_offset (out_found_offset),
    .out_status       (out_status),
    .out_occupancy    (out_occupancy)
  );

endmodule
